/* src/fudec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fudec_pkg
// Character codes, escape phase codes and the byte classifiers shared by the
// urlencoded splitter/decoder.
// ----------------------------------------------------------------------------
package fudec_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHAR_QMARK = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CHAR_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Escape phase codes
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    logic       field_end;
    logic       pair_end;
    logic       blank_name_error;
  } result_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Close a pending escape: a good first digit seen with the second pending
  // gives its one-digit value, anything else gives '?'.
  function automatic logic [7:0] finish_escape(input logic [1:0] phase,
                                               input logic       first_ok,
                                               input logic [3:0] digit);
    logic [7:0] r;
    r = CHAR_QMARK;
    if (phase == ESC_SECOND && first_ok) begin
      r = {4'd0, digit};
    end
    return r;
  endfunction

endpackage

/* src/form_urlencoded_splitter_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urlencoded_splitter_decoder
// Splits a urlencoded query string into names and values and decodes '+'
// and %XX escapes, one raw byte per item in, at most one result per item out.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  input   | item_valid / item_stall    | in_byte, is_last
//  output  | result_valid / result_stall| out_byte, byte_valid, in_value,
//          |                            | field_end, pair_end, blank_name_error
//
//  One item per cycle sustained while the result side does not stall. An
//  accepted item sits in the input register, is decoded against the parser
//  state, and its result (if any) is registered in the result register.
//  Items that produce no result ('%', first escape digit) only advance state.
//  A stalled result register holds the input register, which then stalls
//  the input side; a free result slot lets both move every cycle.
//  rst (synchronous) empties both registers and returns the parser to the
//  start of a name with no escape pending.
//
module form_urlencoded_splitter_decoder
  import fudec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,

  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,

  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       in_value,
  output logic       field_end,
  output logic       pair_end,
  output logic       blank_name_error
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Parser state
  logic [1:0] escape_phase, escape_phase_next;
  logic [3:0] escape_digit, escape_digit_next;
  logic       escape_first_ok, escape_first_ok_next;
  logic       value_phase, value_phase_next;
  logic       name_nonblank, name_nonblank_next;

  // Result register
  result_t    res;
  result_t    res_next;
  logic       emit;

  logic       out_free;
  logic       s1_fire;
  logic       accept;

  // Decode of the item in the input register
  always_comb begin
    logic       delim;
    logic       have;
    logic       close;
    logic [7:0] ob;
    hex_t       h;

    h                    = hex_decode(s1_byte);
    delim                = value_phase ? (s1_byte == CHAR_AMP) : (s1_byte == CHAR_EQ);
    have                 = 1'b0;
    ob                   = 8'd0;
    escape_phase_next    = escape_phase;
    escape_digit_next    = escape_digit;
    escape_first_ok_next = escape_first_ok;
    name_nonblank_next   = name_nonblank;
    value_phase_next     = value_phase;

    if (delim) begin
      // A delimiter always ends the field; flush any pending escape.
      if (escape_phase != ESC_NONE) begin
        ob                = finish_escape(escape_phase, escape_first_ok, escape_digit);
        have              = 1'b1;
        escape_phase_next = ESC_NONE;
      end
    end else begin
      if (!value_phase && !is_blank(s1_byte)) begin
        name_nonblank_next = 1'b1;
      end
      unique case (escape_phase)
        ESC_NONE: begin
          if (s1_byte == CHAR_PLUS) begin
            ob   = CHAR_SPACE;
            have = 1'b1;
          end else if (s1_byte == CHAR_PCT) begin
            escape_phase_next = ESC_FIRST;
          end else begin
            ob   = s1_byte;
            have = 1'b1;
          end
        end
        ESC_FIRST: begin
          escape_first_ok_next = h.ok;
          escape_digit_next    = h.val;
          escape_phase_next    = ESC_SECOND;
        end
        default: begin
          if (!escape_first_ok) begin
            ob = CHAR_QMARK;
          end else if (h.ok) begin
            ob = {escape_digit, h.val};
          end else begin
            ob = {4'd0, escape_digit};
          end
          have              = 1'b1;
          escape_phase_next = ESC_NONE;
        end
      endcase
      // End of string cuts the escape short.
      if (s1_last && escape_phase_next != ESC_NONE) begin
        ob   = finish_escape(escape_phase_next, escape_first_ok_next, escape_digit_next);
        have = 1'b1;
        escape_phase_next = ESC_NONE;
      end
    end

    close = delim || s1_last;
    emit  = have || close;

    res_next.out_byte         = ob;
    res_next.byte_valid       = have;
    res_next.in_value         = value_phase;
    res_next.field_end        = close;
    res_next.pair_end         = s1_last || (delim && value_phase);
    res_next.blank_name_error = close && !value_phase && !name_nonblank_next;

    if (close) begin
      value_phase_next     = s1_last ? 1'b0 : !value_phase;
      name_nonblank_next   = 1'b0;
      escape_phase_next    = ESC_NONE;
      escape_digit_next    = 4'd0;
      escape_first_ok_next = 1'b0;
    end
  end

  // Handshake: the input register drains whenever its result has room.
  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && (!emit || out_free);
  assign item_stall = s1_valid && !s1_fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      result_valid    <= 1'b0;
      escape_phase    <= ESC_NONE;
      escape_digit    <= 4'd0;
      escape_first_ok <= 1'b0;
      value_phase     <= 1'b0;
      name_nonblank   <= 1'b0;
    end else begin
      // Input register: load on accept, drop once decoded.
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      // Result register: clear when taken, load when a result is produced.
      if (s1_fire && emit) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      // Advance parser state once per decoded item.
      if (s1_fire) begin
        escape_phase    <= escape_phase_next;
        escape_digit    <= escape_digit_next;
        escape_first_ok <= escape_first_ok_next;
        value_phase     <= value_phase_next;
        name_nonblank   <= name_nonblank_next;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= in_byte;
      s1_last <= is_last;
    end
    if (s1_fire && emit) begin
      res <= res_next;
    end
  end

  assign out_byte         = res.out_byte;
  assign byte_valid       = res.byte_valid;
  assign in_value         = res.in_value;
  assign field_end        = res.field_end;
  assign pair_end         = res.pair_end;
  assign blank_name_error = res.blank_name_error;

endmodule

/* src/fudec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fudec_checker
// Port-level checks on the result stream of the urlencoded splitter/decoder.
// ----------------------------------------------------------------------------
module fudec_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       in_value,
  input logic       field_end,
  input logic       pair_end,
  input logic       blank_name_error
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte)
      && $stable(field_end))
    else $error("stalled result changed");

  // A result with no data byte must end a field and carry a zero byte
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> field_end && out_byte == 8'd0)
    else $error("empty result without field end");

  // Pair end only on a field end
  a_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && pair_end |-> field_end)
    else $error("pair end without field end");

  // Blank-name flag only closing a name
  a_blank: assert property (@(posedge clk) disable iff (rst)
    result_valid && blank_name_error |-> field_end && !in_value)
    else $error("blank name flag outside a name end");

  // A value closes only by pair end
  a_value_close: assert property (@(posedge clk) disable iff (rst)
    result_valid && field_end && in_value |-> pair_end)
    else $error("value closed without pair end");

endmodule

bind form_urlencoded_splitter_decoder fudec_checker u_fudec_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .out_byte         (out_byte),
  .byte_valid       (byte_valid),
  .in_value         (in_value),
  .field_end        (field_end),
  .pair_end         (pair_end),
  .blank_name_error (blank_name_error)
);

/* bench/query_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_decode_checker
// Watches both channels of the urlencoded splitter/decoder, predicts the
// result of every accepted raw byte and compares each accepted result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module query_decode_checker
  import fudec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,

  input  logic       item_valid,
  input  logic       item_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,

  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic       in_value,
  input  logic       field_end,
  input  logic       pair_end,
  input  logic       blank_name_error,

  output int         mismatch_count,
  output int         pending_count
);

  // Parser state of the prediction
  logic [1:0] esc_phase;
  logic [3:0] esc_digit;
  logic       esc_first_ok;
  logic       value_phase;
  logic       name_nonblank;

  result_t expected_results[$];
  result_t seen;
  result_t want;
  result_t predicted;
  logic    emits;
  int      errors;

  // {ok, value} of one hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic ws_char(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C ||
           c == 8'h0D;
  endfunction

  // Byte that an escape cut short by a field end turns into
  function automatic logic [7:0] cut_escape_byte();
    if (esc_phase == ESC_SECOND && esc_first_ok) return {4'd0, esc_digit};
    return CHAR_QMARK;
  endfunction

  task automatic decode_raw_byte(input logic [7:0] b, input logic last,
                                 output logic emit, output result_t r);
    logic       delim;
    logic       have;
    logic       close;
    logic [7:0] ob;
    logic [4:0] h;
    delim = value_phase ? (b == CHAR_AMP) : (b == CHAR_EQ);
    have  = 1'b0;
    ob    = 8'd0;
    if (delim) begin
      if (esc_phase != ESC_NONE) begin
        ob        = cut_escape_byte();
        have      = 1'b1;
        esc_phase = ESC_NONE;
      end
    end else begin
      if (!value_phase && !ws_char(b)) name_nonblank = 1'b1;
      case (esc_phase)
        ESC_NONE: begin
          if (b == CHAR_PLUS) begin
            ob   = CHAR_SPACE;
            have = 1'b1;
          end else if (b == CHAR_PCT) begin
            esc_phase = ESC_FIRST;
          end else begin
            ob   = b;
            have = 1'b1;
          end
        end
        ESC_FIRST: begin
          h            = hex_digit(b);
          esc_first_ok = h[4];
          esc_digit    = h[3:0];
          esc_phase    = ESC_SECOND;
        end
        default: begin
          h = hex_digit(b);
          if (!esc_first_ok) ob = CHAR_QMARK;
          else if (h[4]) ob = {esc_digit, h[3:0]};
          else ob = {4'd0, esc_digit};
          have      = 1'b1;
          esc_phase = ESC_NONE;
        end
      endcase
      if (last && esc_phase != ESC_NONE) begin
        ob        = cut_escape_byte();
        have      = 1'b1;
        esc_phase = ESC_NONE;
      end
    end
    close = delim || last;
    emit  = have || close;
    r.out_byte         = have ? ob : 8'd0;
    r.byte_valid       = have;
    r.in_value         = value_phase;
    r.field_end        = close;
    r.pair_end         = last || (delim && value_phase);
    r.blank_name_error = close && !value_phase && !name_nonblank;
    if (close) begin
      value_phase   = last ? 1'b0 : ~value_phase;
      name_nonblank = 1'b0;
      esc_phase     = ESC_NONE;
      esc_digit     = 4'd0;
      esc_first_ok  = 1'b0;
    end
  endtask

  task automatic check_field(input string label, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      esc_phase     = ESC_NONE;
      esc_digit     = 4'd0;
      esc_first_ok  = 1'b0;
      value_phase   = 1'b0;
      name_nonblank = 1'b0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (result_valid && !result_stall) begin
        seen = '{out_byte, byte_valid, in_value, field_end, pair_end,
                 blank_name_error};
        if (expected_results.size() == 0) begin
          $display("%0t: result %0h arrived with nothing expected", $time, seen);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", want.out_byte, seen.out_byte);
          check_field("byte_valid", want.byte_valid, seen.byte_valid);
          check_field("in_value", want.in_value, seen.in_value);
          check_field("field_end", want.field_end, seen.field_end);
          check_field("pair_end", want.pair_end, seen.pair_end);
          check_field("blank_name_error", want.blank_name_error,
                      seen.blank_name_error);
        end
      end
      if (item_valid && !item_stall) begin
        decode_raw_byte(in_byte, is_last, emits, predicted);
        if (emits) expected_results.push_back(predicted);
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_results.size();
  end

endmodule

/* bench/form_urlencoded_splitter_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urlencoded_splitter_decoder_tb
// Feeds raw query-string bytes into the splitter/decoder: a directed run over
// the escape, delimiter and blank-name corner cases, then random query
// strings built mostly from well-formed pairs with some noise. Both sides
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module form_urlencoded_splitter_decoder_tb;
  import fudec_pkg::*;

  // Cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
  } raw_item_t;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic [7:0] in_byte;
  logic       is_last;
  logic       result_valid;
  logic       result_stall;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       in_value;
  logic       field_end;
  logic       pair_end;
  logic       blank_name_error;

  int mismatch_count;
  int pending_count;

  raw_item_t query_bytes[$];

  form_urlencoded_splitter_decoder DUT (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .in_byte          (in_byte),
    .is_last          (is_last),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .out_byte         (out_byte),
    .byte_valid       (byte_valid),
    .in_value         (in_value),
    .field_end        (field_end),
    .pair_end         (pair_end),
    .blank_name_error (blank_name_error)
  );

  query_decode_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .in_byte          (in_byte),
    .is_last          (is_last),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .out_byte         (out_byte),
    .byte_valid       (byte_valid),
    .in_value         (in_value),
    .field_end        (field_end),
    .pair_end         (pair_end),
    .blank_name_error (blank_name_error),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last);
    query_bytes.push_back('{b, last});
  endtask

  // Push a string; the last flag, if asked, lands on its final character
  task automatic push_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s.getc(i), last_at_end && (i == s.len() - 1));
    end
  endtask

  // Random hex digit, either letter case
  function automatic logic [7:0] rand_hex();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 10) return "0" + v;
    return ($urandom_range(1) ? "a" : "A") + v - 8'd10;
  endfunction

  // Space, tab, LF, VT, FF or CR
  function automatic logic [7:0] rand_blank();
    int v;
    v = $urandom_range(5);
    return (v == 5) ? CHAR_SPACE : 8'h09 + 8'(v);
  endfunction

  // One name or value of random tokens. The field's own delimiter only shows up
  // through the random-byte tokens and arbitrary escape digits, where it cuts the field short.
  task automatic gen_field(input logic is_value);
    logic [7:0] delim;
    logic [7:0] other;
    logic [7:0] b;
    int         len;
    int         r;
    int         ndig;
    delim = is_value ? CHAR_AMP : CHAR_EQ;
    other = is_value ? CHAR_EQ : CHAR_AMP;
    len   = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 6);
    for (int t = 0; t < len; t++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        b = 8'($urandom_range(8'h21, 8'h7E));
        push_byte((b == delim) ? "x" : b, 1'b0);
      end else if (r < 45) begin
        push_byte(CHAR_PLUS, 1'b0);
      end else if (r < 65) begin
        // well-formed escape, now and then truncated
        ndig = (r < 60) ? 2 : $urandom_range(1);
        push_byte(CHAR_PCT, 1'b0);
        for (int d = 0; d < ndig; d++) push_byte(rand_hex(), 1'b0);
      end else if (r < 72) begin
        // escape with arbitrary digit bytes
        push_byte(CHAR_PCT, 1'b0);
        push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'($urandom_range(255)), 1'b0);
      end else if (r < 80) begin
        push_byte(rand_blank(), 1'b0);
      end else if (r < 85) begin
        push_byte(other, 1'b0);
      end else begin
        push_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  // One query string: mostly name=value pairs joined by '&', sometimes
  // ending inside a name, sometimes pure noise. The last flag goes on
  // whatever byte ends up final.
  task automatic gen_query();
    int        start_size;
    int        npairs;
    int        nblank;
    raw_item_t tail;
    start_size = query_bytes.size();
    if ($urandom_range(99) < 15) begin
      nblank = $urandom_range(1, 10);
      for (int j = 0; j < nblank; j++) push_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      npairs = $urandom_range(1, 4);
      for (int p = 0; p < npairs; p++) begin
        if ($urandom_range(99) < 10) begin
          nblank = $urandom_range(1, 3);
          for (int j = 0; j < nblank; j++) push_byte(rand_blank(), 1'b0);
        end else begin
          gen_field(1'b0);
        end
        if (p == npairs - 1 && $urandom_range(99) < 15) break;
        push_byte(CHAR_EQ, 1'b0);
        gen_field(1'b1);
        if (p != npairs - 1) push_byte(CHAR_AMP, 1'b0);
      end
    end
    if (query_bytes.size() == start_size) push_byte(8'($urandom_range(255)), 1'b0);
    tail      = query_bytes.pop_back();
    tail.last = 1'b1;
    query_bytes.push_back(tail);
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, then every queued item in order with random idle cycles.
  // Valid stays high across back-to-back items; the payload holds while
  // the block stalls.
  // --------------------------------------------------------------------------
  initial begin : drive_items
    raw_item_t cur;
    int        directed_count;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    in_byte    <= 8'd0;
    is_last    <= 1'b0;

    // empty name with an all-ones value, closed by '&'
    push_text("=", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("&", 1'b0);
    // whitespace-only name; escape %41 and '+' in the value
    push_text("\t=%41+&", 1'b0);
    // zero byte and '&' as name data, bad first digit, then '='
    push_byte(8'h00, 1'b0);
    push_text("&%z9=", 1'b0);
    // bad second digit, '=' as value data, escape cut by '&' with no digits
    push_text("%4g=%&", 1'b0);
    // string ends inside a name while an escape has one digit
    push_text("%a", 1'b1);
    // escape cut by '=' with no digits, then '%' as the final byte
    push_text("%=%", 1'b1);
    // trailing '=' as the whole string
    push_text("=", 1'b1);

    directed_count = query_bytes.size();
    while (query_bytes.size() < directed_count + RANDOM_ITEMS) gen_query();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int idx = 0; idx < query_bytes.size(); idx++) begin
      cur = query_bytes[idx];
      // no idling on a stretch in the middle of the run
      if (!(idx >= 500 && idx < 700)) begin
        while ($urandom_range(99) < 12) begin
          item_valid <= 1'b0;
          @(posedge clk);
        end
      end
      item_valid <= 1'b1;
      in_byte    <= cur.raw;
      is_last    <= cur.last;
      @(posedge clk);
      while (item_stall) @(posedge clk);
    end
    item_valid <= 1'b0;

    // drain: wait for every predicted result, then idle before the report
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off that backs the block up into
  // its input, and a stretch that takes every result at once.
  // --------------------------------------------------------------------------
  initial begin : drive_result_stall
    int rx_cycle;
    rx_cycle = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 300 && rx_cycle < 380) begin
        result_stall <= 1'b1;
      end else if (rx_cycle >= 900 && rx_cycle < 1200) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < 12);
      end
    end
  end

  // Hang detection: count cycles with no handshake on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
